### rtl/ohms_law_pair_solver_macros.svh
// assertion macros for the ohm's law pair solver checker
// expects clk and rst_n in the scope where a macro is used
`ifndef OHMS_LAW_PAIR_SOLVER_MACROS_SVH
`define OHMS_LAW_PAIR_SOLVER_MACROS_SVH

// implication checked out of reset
`define OLPS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, also watched while reset is held
`define OLPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/olps_pkg.sv
// shared types, constants and step functions for the ohm's law pair solver
// no dependencies
`timescale 1ns / 1ps

package olps_pkg;

  localparam int STEPS          = 64;
  localparam int LATENCY        = 2 * STEPS + 5;
  localparam int WORD_BITS_DEF  = 64;
  localparam int FRAC_BITS_DEF  = 20;

  localparam logic [2:0] REQ_VI = 3'd0;
  localparam logic [2:0] REQ_VR = 3'd1;
  localparam logic [2:0] REQ_IR = 3'd2;
  localparam logic [2:0] REQ_VP = 3'd3;
  localparam logic [2:0] REQ_IP = 3'd4;
  localparam logic [2:0] REQ_RP = 3'd5;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] first_operand;
    logic [63:0] second_operand;
  } olps_in_t;

  typedef struct packed {
    logic [63:0] volts;
    logic [63:0] amps;
    logic [63:0] ohms;
    logic [63:0] watts;
    logic        range_error;
  } olps_out_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] lo;
    logic [63:0] b;
    logic [63:0] q;
    logic        ovf;
  } olps_div_t;

  typedef struct packed {
    logic [65:0]  rem;
    logic [127:0] n;
    logic [63:0]  r;
  } olps_root_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  sel;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] d1;
    logic [63:0] sr;
    logic [63:0] sp;
    logic [63:0] ma;
    logic [63:0] mb;
    logic        sat;
  } olps_item_t;

  typedef struct packed {
    logic [63:0] val;
    logic        sat;
  } olps_res_t;

  // one restoring division step, one quotient bit
  function automatic olps_div_t div_step(olps_div_t d);
    olps_div_t   o;
    logic [64:0] rem2;
    logic [64:0] diff;
    logic        ge;
    rem2   = {d.rem, d.lo[63]};
    diff   = rem2 - {1'b0, d.b};
    ge     = (rem2 >= {1'b0, d.b});
    o      = d;
    o.rem  = ge ? diff[63:0] : rem2[63:0];
    o.lo   = {d.lo[62:0], 1'b0};
    o.q    = {d.q[62:0], ge};
    return o;
  endfunction

  // one digit-recurrence square root step, one root bit
  function automatic olps_root_t root_step(olps_root_t s);
    olps_root_t  o;
    logic [67:0] rem2;
    logic [67:0] trial;
    logic [67:0] diff;
    logic        ge;
    rem2   = {s.rem, s.n[127:126]};
    trial  = {2'b00, s.r, 2'b01};
    diff   = rem2 - trial;
    ge     = (rem2 >= trial);
    o.rem  = ge ? diff[65:0] : rem2[65:0];
    o.n    = {s.n[125:0], 2'b00};
    o.r    = {s.r[62:0], ge};
    return o;
  endfunction

  function automatic olps_res_t div_final(olps_div_t d, logic [63:0] wmax);
    olps_res_t o;
    o.sat = d.ovf || (d.q > wmax);
    o.val = o.sat ? wmax : d.q;
    return o;
  endfunction

endpackage

### rtl/olps_cell.sv
// one cell of the divide / square root chain: a quotient bit and, with HAS_ROOTS, two root bits
// depends on olps_pkg
`timescale 1ns / 1ps

module olps_cell #(
  parameter bit HAS_ROOTS = 1'b1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  olps_pkg::olps_item_t item_i,
  input  olps_pkg::olps_div_t  div_i,
  input  olps_pkg::olps_root_t rx_i,
  input  olps_pkg::olps_root_t ry_i,
  output olps_pkg::olps_item_t item_o,
  output olps_pkg::olps_div_t  div_o,
  output olps_pkg::olps_root_t rx_o,
  output olps_pkg::olps_root_t ry_o
);
  import olps_pkg::*;

  olps_item_t item_r;
  olps_div_t  div_r, div_nxt;

  always_comb begin
    div_nxt = div_step(div_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else begin
      item_r <= item_i;
    end
    div_r <= div_nxt;
  end

  assign item_o = item_r;
  assign div_o  = div_r;

  if (HAS_ROOTS) begin : g_roots
    olps_root_t rx_r, ry_r, rx_nxt, ry_nxt;

    always_comb begin
      rx_nxt = root_step(rx_i);
      ry_nxt = root_step(ry_i);
    end

    always_ff @(posedge clk) begin
      rx_r <= rx_nxt;
      ry_r <= ry_nxt;
    end

    assign rx_o = rx_r;
    assign ry_o = ry_r;
  end else begin : g_no_roots
    assign rx_o = '0;
    assign ry_o = '0;
  end

endmodule

### rtl/olps_mul.sv
// two-stage fixed-point multiplier: 32x32 partial products, then sum and saturate
// depends on olps_pkg
`timescale 1ns / 1ps

module olps_mul #(
  parameter int WORD_BITS     = olps_pkg::WORD_BITS_DEF,
  parameter int FRACTION_BITS = olps_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  olps_pkg::olps_item_t item_i,
  input  logic [63:0]          a_i,
  input  logic [63:0]          b_i,
  output olps_pkg::olps_item_t item_o,
  output olps_pkg::olps_res_t  res_o
);
  import olps_pkg::*;

  localparam logic [63:0] WMAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - WORD_BITS);

  olps_item_t  item1_r, item2_r;
  logic [63:0] ll_r, lh_r, hl_r, hh_r;
  olps_res_t   res_r, res_nxt;
  logic [127:0] prod, shifted;

  always_comb begin
    prod    = {64'b0, ll_r} + {32'b0, lh_r, 32'b0} + {32'b0, hl_r, 32'b0} + {hh_r, 64'b0};
    shifted = prod >> FRACTION_BITS;
    res_nxt.sat = (|shifted[127:64]) || (shifted[63:0] > WMAX);
    res_nxt.val = res_nxt.sat ? WMAX : shifted[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item1_r.valid <= 1'b0;
      item2_r.valid <= 1'b0;
    end else begin
      item1_r <= item_i;
      item2_r <= item1_r;
    end
    ll_r  <= a_i[31:0]  * b_i[31:0];
    lh_r  <= a_i[31:0]  * b_i[63:32];
    hl_r  <= a_i[63:32] * b_i[31:0];
    hh_r  <= a_i[63:32] * b_i[63:32];
    res_r <= res_nxt;
  end

  assign item_o = item2_r;
  assign res_o  = res_r;

endmodule

### rtl/ohms_law_pair_solver.sv
// ohm's law pair solver: one transaction per cycle
// a chain of 64 cells takes the first divide and both roots, a bit per cell;
// two 2-stage multipliers follow, then a second chain of 64 divide cells.
// latency is set by both 64-bit quotient chains, both multipliers and the output register; busy never rises.
// synchronous active-low reset clears the valid bits and the result strobe.
// depends on olps_pkg, olps_cell, olps_mul
`timescale 1ns / 1ps

module ohms_law_pair_solver #(
  parameter int WORD_BITS     = olps_pkg::WORD_BITS_DEF,
  parameter int FRACTION_BITS = olps_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  olps_pkg::olps_in_t  in_data,
  output logic                out_valid,
  output olps_pkg::olps_out_t out_data
);
  import olps_pkg::*;

  localparam logic [63:0] WMAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - WORD_BITS);

  olps_item_t item1 [0:STEPS];
  olps_div_t  div1  [0:STEPS];
  olps_root_t rx1   [0:STEPS];
  olps_root_t ry1   [0:STEPS];
  olps_item_t item2 [0:STEPS];
  olps_div_t  div2  [0:STEPS];

  olps_item_t entry_item, it_a, it_a_out, it_b, it_b_out, it_c, p2;
  olps_div_t  entry_div, p2_div;
  olps_root_t entry_rx, entry_ry;
  olps_res_t  d1_res, d2_res, mul_a_res, mul_b_res;
  logic [63:0] ea, eb, ma_a, ma_b, p2_a, p2_b;
  logic [63:0] v, i, r, p;
  logic        bad_sel;
  logic        out_valid_r;
  olps_out_t   out_data_r, out_nxt;

  assign busy = 1'b0;

  // entry: mask operands and seed the first chain
  always_comb begin
    entry_item       = '0;
    entry_item.valid = start && !busy;
    entry_item.sel   = in_data.req_type;
    entry_item.x     = in_data.first_operand & WMAX;
    entry_item.y     = in_data.second_operand & WMAX;
    if (entry_item.sel == REQ_VP || entry_item.sel == REQ_IP) begin
      ea = entry_item.y;
      eb = entry_item.x;
    end else begin
      ea = entry_item.x;
      eb = entry_item.y;
    end
    entry_div.rem = ea >> (64 - FRACTION_BITS);
    entry_div.lo  = ea << FRACTION_BITS;
    entry_div.b   = eb;
    entry_div.q   = '0;
    entry_div.ovf = (eb == 64'd0) || (entry_div.rem >= eb);
    entry_rx.rem  = '0;
    entry_rx.n    = {64'b0, entry_item.x} << FRACTION_BITS;
    entry_rx.r    = '0;
    entry_ry.rem  = '0;
    entry_ry.n    = {64'b0, entry_item.y} << FRACTION_BITS;
    entry_ry.r    = '0;
  end

  assign item1[0] = entry_item;
  assign div1[0]  = entry_div;
  assign rx1[0]   = entry_rx;
  assign ry1[0]   = entry_ry;

  for (genvar k = 0; k < STEPS; k++) begin : g_chain1
    olps_cell #(.HAS_ROOTS(1'b1)) u_cell1 (
      .clk    (clk),
      .rst_n  (rst_n),
      .item_i (item1[k]),
      .div_i  (div1[k]),
      .rx_i   (rx1[k]),
      .ry_i   (ry1[k]),
      .item_o (item1[k+1]),
      .div_o  (div1[k+1]),
      .rx_o   (rx1[k+1]),
      .ry_o   (ry1[k+1])
    );
  end

  // first quotient and roots done, pick the first product operands
  always_comb begin
    d1_res  = div_final(div1[STEPS], WMAX);
    it_a    = item1[STEPS];
    it_a.d1 = d1_res.val;
    it_a.sr = (rx1[STEPS].r > WMAX) ? WMAX : rx1[STEPS].r;
    it_a.sp = (ry1[STEPS].r > WMAX) ? WMAX : ry1[STEPS].r;
    it_a.sat = it_a.sat | (d1_res.sat && (it_a.sel == REQ_VI || it_a.sel == REQ_VR ||
                                          it_a.sel == REQ_VP || it_a.sel == REQ_IP));
    unique case (it_a.sel)
      REQ_VR: begin
        ma_a = it_a.x;
        ma_b = it_a.d1;
      end
      REQ_RP: begin
        ma_a = it_a.sp;
        ma_b = it_a.sr;
      end
      default: begin
        ma_a = it_a.x;
        ma_b = it_a.y;
      end
    endcase
  end

  olps_mul #(.WORD_BITS(WORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_mul_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .item_i (it_a),
    .a_i    (ma_a),
    .b_i    (ma_b),
    .item_o (it_a_out),
    .res_o  (mul_a_res)
  );

  always_comb begin
    it_b     = it_a_out;
    it_b.ma  = mul_a_res.val;
    it_b.sat = it_b.sat | (mul_a_res.sat && (it_b.sel == REQ_VI || it_b.sel == REQ_VR ||
                                             it_b.sel == REQ_IR || it_b.sel == REQ_RP));
  end

  // second product: power from the current and the voltage just formed
  olps_mul #(.WORD_BITS(WORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_mul_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .item_i (it_b),
    .a_i    (it_b.ma),
    .b_i    (it_b.x),
    .item_o (it_b_out),
    .res_o  (mul_b_res)
  );

  always_comb begin
    it_c     = it_b_out;
    it_c.mb  = mul_b_res.val;
    it_c.sat = it_c.sat | (mul_b_res.sat && (it_c.sel == REQ_IR));
    unique case (it_c.sel)
      REQ_VP: begin
        p2_a = it_c.x;
        p2_b = it_c.d1;
      end
      REQ_IP: begin
        p2_a = it_c.d1;
        p2_b = it_c.x;
      end
      REQ_RP: begin
        p2_a = it_c.sp;
        p2_b = it_c.sr;
      end
      default: begin
        p2_a = it_c.x;
        p2_b = it_c.y;
      end
    endcase
    p2_div.rem = p2_a >> (64 - FRACTION_BITS);
    p2_div.lo  = p2_a << FRACTION_BITS;
    p2_div.b   = p2_b;
    p2_div.q   = '0;
    p2_div.ovf = (p2_b == 64'd0) || (p2_div.rem >= p2_b);
  end

  assign item2[0] = it_c;
  assign div2[0]  = p2_div;

  for (genvar k = 0; k < STEPS; k++) begin : g_chain2
    olps_cell #(.HAS_ROOTS(1'b0)) u_cell2 (
      .clk    (clk),
      .rst_n  (rst_n),
      .item_i (item2[k]),
      .div_i  (div2[k]),
      .rx_i   ('0),
      .ry_i   ('0),
      .item_o (item2[k+1]),
      .div_o  (div2[k+1]),
      .rx_o   (),
      .ry_o   ()
    );
  end

  // assemble the four quantities by pair
  always_comb begin
    p       = '0;
    v       = '0;
    i       = '0;
    r       = '0;
    bad_sel = 1'b0;
    p2      = item2[STEPS];
    d2_res  = div_final(div2[STEPS], WMAX);
    unique case (p2.sel)
      REQ_VI: begin
        v = p2.x; i = p2.y; r = p2.d1; p = p2.ma;
      end
      REQ_VR: begin
        v = p2.x; r = p2.y; i = p2.d1; p = p2.ma;
      end
      REQ_IR: begin
        i = p2.x; r = p2.y; v = p2.ma; p = p2.mb;
      end
      REQ_VP: begin
        v = p2.x; p = p2.y; i = p2.d1; r = d2_res.val;
      end
      REQ_IP: begin
        i = p2.x; p = p2.y; v = p2.d1; r = d2_res.val;
      end
      REQ_RP: begin
        r = p2.x; p = p2.y; v = p2.ma; i = d2_res.val;
      end
      default: begin
        bad_sel = 1'b1;
      end
    endcase
    out_nxt.volts = v;
    out_nxt.amps  = i;
    out_nxt.ohms  = r;
    out_nxt.watts = p;
    out_nxt.range_error = bad_sel || p2.sat ||
                          (d2_res.sat && (p2.sel == REQ_VP || p2.sel == REQ_IP ||
                                          p2.sel == REQ_RP)) ||
                          (v == 64'd0) || (i == 64'd0) || (r == 64'd0) || (p == 64'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= p2.valid;
    end
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/olps_chk.sv
// port-level checker for the ohm's law pair solver, bound to the top level
// depends on olps_pkg and ohms_law_pair_solver_macros.svh
`timescale 1ns / 1ps
`include "ohms_law_pair_solver_macros.svh"

module olps_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input olps_pkg::olps_in_t  in_data,
  input logic                out_valid,
  input olps_pkg::olps_out_t out_data
);
  import olps_pkg::*;

  localparam int AW = $clog2(LATENCY + 1);

  logic [AW-1:0] age_r, age_nxt;
  logic          aged;

  // cycles since reset, so lookbacks never reach into reset
  always_comb begin
    age_nxt = (age_r == AW'(LATENCY)) ? age_r : age_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_r <= '0;
    end else begin
      age_r <= age_nxt;
    end
  end

  assign aged = (age_r == AW'(LATENCY));

  `OLPS_ASSERT(a_fixed_latency, aged, out_valid == $past(start && !busy, LATENCY), "result strobe does not follow transaction by fixed latency")
  `OLPS_ASSERT(a_clean_nonzero, out_valid && !out_data.range_error, out_data.volts != 64'd0 && out_data.amps != 64'd0 && out_data.ohms != 64'd0 && out_data.watts != 64'd0, "zero quantity without range error")
  `OLPS_ASSERT(a_bad_selector, aged && out_valid && $past(in_data.req_type, LATENCY) > 3'd5, out_data.range_error && out_data.volts == 64'd0 && out_data.watts == 64'd0, "unknown pair not flagged")
  `OLPS_ASSERT_NEXT(a_reset_quiet, !rst_n, !out_valid, "result strobe right after reset")

endmodule

bind ohms_law_pair_solver olps_chk u_olps_chk (.*);
